// File: hw/rtl/bfre_pkg.sv
`default_nettype none

package bfre_pkg;

  // Bitmap geometry.
  localparam int TABLE_BYTES = 496;
  localparam int IDX_W       = 12;
  localparam int BYTE_IDX_W  = IDX_W - 3;
  localparam int LEN_W       = 12;
  localparam int MAX_RES     = 4;
  localparam int CNT_W       = 3;
  localparam int PTR_W       = 2;

  // Field widths.
  localparam int MAP_W    = 8;
  localparam int OFFS_W   = 63;
  localparam int BYTES_W  = 21;
  localparam int OUT_DATA_W = 88;

  // Block size shifts and the page-mode start adjustment.
  localparam int DATA_SHIFT = 6;
  localparam int PAGE_SHIFT = 9;
  localparam logic [OFFS_W-1:0] PAGE_ADJ = OFFS_W'(64'h200);

  localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};
  localparam logic [BYTE_IDX_W-1:0] LAST_BYTE_IDX = BYTE_IDX_W'(TABLE_BYTES - 1);

  // Configuration register indexes.
  localparam int CFG_ADDR_W = 1;
  localparam logic [CFG_ADDR_W-1:0] REG_PAGE_MODE   = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_BASE_OFFSET = 1'b1;

  // One extent in block units, before conversion to bytes.
  typedef struct packed {
    logic [IDX_W-1:0] start;
    logic [LEN_W-1:0] len;
    logic             valid;
    logic             done;
  } res_t;

  // The results, up to MAX_RES, caused by one bitmap byte.
  typedef struct packed {
    res_t [MAX_RES-1:0] res;
    logic [CNT_W-1:0]   cnt;
  } grp_t;

endpackage

`default_nettype wire

// File: hw/rtl/bfre_scan.sv
`default_nettype none

module bfre_scan
  import bfre_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  input  wire logic [MAP_W-1:0] in_tdata,
  input  wire logic             in_tlast,
  output grp_t                  grp_o,
  output logic                  grp_valid_o,
  input  wire logic             grp_ready_i
);

  logic             inreg_valid_r;
  logic [MAP_W-1:0] byte_r;
  logic             last_r;
  logic [IDX_W-1:0] blk_idx_r, blk_idx_nxt;
  logic [IDX_W-1:0] run_start_r, run_start_nxt;
  logic [LEN_W-1:0] run_len_r, run_len_nxt;
  logic             take;
  grp_t             grp;

  // Walk the eight bits MSB first, closing runs as one bits arrive.
  always_comb begin
    logic [CNT_W-1:0] n;
    logic             is_final;
    blk_idx_nxt   = blk_idx_r;
    run_start_nxt = run_start_r;
    run_len_nxt   = run_len_r;
    n             = '0;
    grp           = '0;
    is_final      = last_r || (blk_idx_r[IDX_W-1:3] == LAST_BYTE_IDX);
    for (int b = MAP_W - 1; b >= 0; b--) begin
      if (!byte_r[b]) begin
        if (run_len_nxt == '0) begin
          run_start_nxt = blk_idx_nxt;
        end
        if (run_len_nxt != LEN_MAX) begin
          run_len_nxt = run_len_nxt + 1'b1;
        end
      end else if (run_len_nxt != '0) begin
        if (n < CNT_W'(MAX_RES)) begin
          grp.res[n[PTR_W-1:0]].start = run_start_nxt;
          grp.res[n[PTR_W-1:0]].len   = run_len_nxt;
          grp.res[n[PTR_W-1:0]].valid = 1'b1;
          n = n + 1'b1;
        end
        run_len_nxt = '0;
      end
      blk_idx_nxt = blk_idx_nxt + 1'b1;
    end
    // The final byte flushes the open run and always yields a done result.
    if (is_final) begin
      if (run_len_nxt != '0 && n < CNT_W'(MAX_RES)) begin
        grp.res[n[PTR_W-1:0]].start = run_start_nxt;
        grp.res[n[PTR_W-1:0]].len   = run_len_nxt;
        grp.res[n[PTR_W-1:0]].valid = 1'b1;
        n = n + 1'b1;
      end
      if (n == '0) begin
        n = CNT_W'(1);
      end
      grp.res[PTR_W'(n - 1'b1)].done = 1'b1;
      blk_idx_nxt   = '0;
      run_start_nxt = '0;
      run_len_nxt   = '0;
    end
    grp.cnt = n;
  end

  // A byte with no result leaves without waiting for the drain side.
  assign take        = inreg_valid_r && ((grp.cnt == '0) || grp_ready_i);
  assign in_tready   = !inreg_valid_r || take;
  assign grp_valid_o = inreg_valid_r && (grp.cnt != '0);
  assign grp_o       = grp;

  // Input register and scan state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inreg_valid_r <= 1'b0;
      blk_idx_r     <= '0;
      run_start_r   <= '0;
      run_len_r     <= '0;
    end else begin
      if (take) begin
        blk_idx_r   <= blk_idx_nxt;
        run_start_r <= run_start_nxt;
        run_len_r   <= run_len_nxt;
      end
      if (in_tready) begin
        inreg_valid_r <= in_tvalid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      byte_r <= in_tdata;
      last_r <= in_tlast;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/bfre_drain.sv
`default_nettype none

module bfre_drain
  import bfre_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  page_mode_i,
  input  wire logic [OFFS_W-1:0]     base_adj_i,
  input  wire grp_t                  grp_i,
  input  wire logic                  grp_valid_i,
  output logic                       grp_ready_o,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,
  output logic                       out_tuser,
  output logic                       out_tlast
);

  grp_t               grp_r;
  logic               gv_r;
  logic [PTR_W-1:0]   ptr_r;
  logic               out_valid_r;
  logic [OFFS_W-1:0]  offs_r, offs_nxt;
  logic [BYTES_W-1:0] bytes_r, bytes_nxt;
  logic               rv_r;
  logic               done_r;
  logic               pop;
  logic               last_slot;
  res_t               head;

  assign head        = grp_r.res[ptr_r];
  assign pop         = gv_r && (!out_valid_r || out_tready);
  assign last_slot   = (ptr_r == PTR_W'(grp_r.cnt - 1'b1));
  assign grp_ready_o = !gv_r || (pop && last_slot);

  // Convert the head extent from blocks to bytes.
  always_comb begin
    offs_nxt  = '0;
    bytes_nxt = '0;
    if (head.valid) begin
      if (page_mode_i) begin
        offs_nxt  = base_adj_i + OFFS_W'({head.start, {PAGE_SHIFT{1'b0}}});
        bytes_nxt = BYTES_W'({head.len, {PAGE_SHIFT{1'b0}}});
      end else begin
        offs_nxt  = base_adj_i + OFFS_W'({head.start, {DATA_SHIFT{1'b0}}});
        bytes_nxt = BYTES_W'({head.len, {DATA_SHIFT{1'b0}}});
      end
    end
  end

  // Group buffer and output register control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gv_r        <= 1'b0;
      ptr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (grp_valid_i && grp_ready_o) begin
        gv_r  <= 1'b1;
        ptr_r <= '0;
      end else if (pop) begin
        if (last_slot) begin
          gv_r <= 1'b0;
        end
        ptr_r <= ptr_r + 1'b1;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (grp_valid_i && grp_ready_o) begin
      grp_r <= grp_i;
    end
    if (pop) begin
      offs_r  <= offs_nxt;
      bytes_r <= bytes_nxt;
      rv_r    <= head.valid;
      done_r  <= head.done;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'({bytes_r, offs_r});
  assign out_tuser  = rv_r;
  assign out_tlast  = done_r;

endmodule

`default_nettype wire

// File: hw/rtl/bitmap_free_run_extractor_top.sv
// Channel   Dir  Data                                         Side bits
// in_       in   tdata[7:0] map_byte                          tlast last_byte
// out_      out  tdata[62:0] run_offset, [83:63] run_bytes    tuser run_valid, tlast done_res
// cfg_      in   index 0 page_mode, index 1 base_offset       wen, addr, wdata[62:0]
//
// One bitmap byte is accepted per cycle unless results stall; it is scanned while it sits
// in the input register. Results leave one per cycle from the output register while
// out_tready is high, so a byte with several extents holds back the next byte.
// A result passes the input register, the group buffer and the output register in turn.
// Reset is synchronous and clears the scan state and the channel valids.
// Output stalls back up through the group buffer into in_tready.
`default_nettype none

module bitmap_free_run_extractor_top
  import bfre_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [MAP_W-1:0]      in_tdata,   // [7:0] map_byte
  input  wire logic                  in_tlast,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,  // [62:0] run_offset, [83:63] run_bytes
  output logic                       out_tuser,  // [0] run_valid
  output logic                       out_tlast,
  input  wire logic                  cfg_wen,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [OFFS_W-1:0]     cfg_wdata
);

  logic              page_mode_r, page_mode_nxt;
  logic [OFFS_W-1:0] base_r, base_nxt;
  logic [OFFS_W-1:0] base_adj_r;
  grp_t              grp;
  logic              grp_valid;
  logic              grp_ready;

  // Register writes; the adjusted start base is kept ready alongside.
  always_comb begin
    page_mode_nxt = page_mode_r;
    base_nxt      = base_r;
    if (cfg_wen) begin
      case (cfg_addr)
        REG_PAGE_MODE:   page_mode_nxt = cfg_wdata[0];
        REG_BASE_OFFSET: base_nxt      = cfg_wdata;
        default:         ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_mode_r <= 1'b0;
      base_r      <= '0;
      base_adj_r  <= '0;
    end else begin
      page_mode_r <= page_mode_nxt;
      base_r      <= base_nxt;
      base_adj_r  <= page_mode_nxt ? (base_nxt - PAGE_ADJ) : base_nxt;
    end
  end

  bfre_scan u_scan (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .grp_o       (grp),
    .grp_valid_o (grp_valid),
    .grp_ready_i (grp_ready)
  );

  bfre_drain u_drain (
    .clk         (clk),
    .rst_n       (rst_n),
    .page_mode_i (page_mode_r),
    .base_adj_i  (base_adj_r),
    .grp_i       (grp),
    .grp_valid_i (grp_valid),
    .grp_ready_o (grp_ready),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast)
  );

endmodule

`default_nettype wire

// File: bench/bfre_checker.sv
`default_nettype none

module bfre_checker
  import bfre_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  input  wire logic                  in_tready,
  input  wire logic [MAP_W-1:0]      in_tdata,   // [7:0] map_byte
  input  wire logic                  in_tlast,
  input  wire logic                  out_tvalid,
  input  wire logic                  out_tready,
  input  wire logic [OUT_DATA_W-1:0] out_tdata,  // [62:0] run_offset, [83:63] run_bytes
  input  wire logic                  out_tuser,  // [0] run_valid
  input  wire logic                  out_tlast,
  input  wire logic                  cfg_wen,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [OFFS_W-1:0]     cfg_wdata,
  output int                         fail_count,
  output int                         extents_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int REPORT_MAX = 10;

  // One free extent as it should leave the block.
  typedef struct {
    logic              valid;
    logic [OFFS_W-1:0] offset;
    logic [BYTES_W-1:0] nbytes;
    logic              done;
  } extent_t;

  // Mirror of the registers and of the scan state.
  logic               page_mode_q;
  logic [OFFS_W-1:0]  base_q;
  logic [IDX_W-1:0]   blk_idx;
  logic [IDX_W-1:0]   run_start;
  logic [LEN_W-1:0]   run_len;
  extent_t            expected_extents[$];

  // Converts a run in block units into byte offset and byte size.
  function automatic extent_t make_extent(input logic valid, input logic [IDX_W-1:0] start,
                                          input logic [LEN_W-1:0] len);
    extent_t           e;
    logic [OFFS_W-1:0] origin;
    int unsigned       shift;
    shift    = page_mode_q ? PAGE_SHIFT : DATA_SHIFT;
    origin   = page_mode_q ? base_q - PAGE_ADJ : base_q;
    e.valid  = valid;
    e.done   = 1'b0;
    e.offset = '0;
    e.nbytes = '0;
    if (valid) begin
      e.offset = origin + (OFFS_W'(start) << shift);
      e.nbytes = BYTES_W'(len) << shift;
    end
    return e;
  endfunction

  // Scans one bitmap byte MSB first and queues the extents it closes.
  function automatic void scan_map_byte(input logic [MAP_W-1:0] map, input logic last_flag);
    extent_t found[MAX_RES];
    int      n;
    logic    is_final;
    n = 0;
    is_final = last_flag || (blk_idx[IDX_W-1:3] == LAST_BYTE_IDX);
    for (int pos = MAP_W - 1; pos >= 0; pos--) begin
      if (!map[pos]) begin
        if (run_len == '0) run_start = blk_idx;
        if (run_len != LEN_MAX) run_len++;
      end else if (run_len != '0) begin
        // A fifth extent in one byte is dropped.
        if (n < MAX_RES) begin
          found[n] = make_extent(1'b1, run_start, run_len);
          n++;
        end
        run_len = '0;
      end
      blk_idx++;
    end
    if (is_final) begin
      if (run_len != '0 && n < MAX_RES) begin
        found[n] = make_extent(1'b1, run_start, run_len);
        n++;
      end
      // A final byte that closes nothing still gives an empty done result.
      if (n == 0) begin
        found[0] = make_extent(1'b0, '0, '0);
        n = 1;
      end
      found[n-1].done = 1'b1;
      blk_idx   = '0;
      run_start = '0;
      run_len   = '0;
    end
    for (int i = 0; i < n; i++) expected_extents.push_back(found[i]);
  endfunction

  function automatic void log_mismatch(input string msg);
    fail_count++;
    if (fail_count <= REPORT_MAX) $display("%0t ns: mismatch: %s", $realtime, msg);
  endfunction

  // Compares one accepted result with the oldest expected extent.
  function automatic void check_extent();
    extent_t            want;
    logic [OFFS_W-1:0]  got_offset;
    logic [BYTES_W-1:0] got_bytes;
    got_offset = out_tdata[OFFS_W-1:0];
    got_bytes  = out_tdata[OFFS_W +: BYTES_W];
    if (expected_extents.size() == 0) begin
      log_mismatch($sformatf("unexpected result valid=%b offset=%h bytes=%h done=%b",
                             out_tuser, got_offset, got_bytes, out_tlast));
    end else begin
      want = expected_extents.pop_front();
      if (want.valid !== out_tuser || want.offset !== got_offset ||
          want.nbytes !== got_bytes || want.done !== out_tlast) begin
        log_mismatch($sformatf("expected valid=%b offset=%h bytes=%h done=%b",
                               want.valid, want.offset, want.nbytes, want.done));
        if (fail_count <= REPORT_MAX) begin
          $display("           actual valid=%b offset=%h bytes=%h done=%b",
                   out_tuser, got_offset, got_bytes, out_tlast);
        end
      end
    end
  endfunction

  // Everything is sampled at the rising edge; outputs are compared before new
  // input bytes are predicted.
  always @(posedge clk) begin
    if (!rst_n) begin
      page_mode_q = 1'b0;
      base_q      = '0;
      blk_idx     = '0;
      run_start   = '0;
      run_len     = '0;
      fail_count  = 0;
      expected_extents.delete();
    end else begin
      if (cfg_wen) begin
        case (cfg_addr)
          REG_PAGE_MODE:   page_mode_q = cfg_wdata[0];
          REG_BASE_OFFSET: base_q = cfg_wdata;
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) check_extent();
      if (in_tvalid && in_tready) scan_map_byte(in_tdata, in_tlast);
    end
    extents_pending = expected_extents.size();
  end

endmodule

`default_nettype wire

// File: bench/tb_bitmap_free_run_extractor_top.sv
`default_nettype none

module tb_bitmap_free_run_extractor_top
  import bfre_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT  = 2000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 10;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [MAP_W-1:0]      in_tdata;
  logic                  in_tlast;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;
  logic                  out_tlast;
  logic                  cfg_wen;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [OFFS_W-1:0]     cfg_wdata;
  int                    fail_count;
  int                    extents_pending;

  bit                    gaps_on;
  bit                    stalls_on;
  bit                    hold_req;
  int unsigned           bytes_sent;
  int unsigned           quiet_cycles;

  bitmap_free_run_extractor_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_wen    (cfg_wen),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  bfre_checker checker_i (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tlast        (in_tlast),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tuser       (out_tuser),
    .out_tlast       (out_tlast),
    .cfg_wen         (cfg_wen),
    .cfg_addr        (cfg_addr),
    .cfg_wdata       (cfg_wdata),
    .fail_count      (fail_count),
    .extents_pending (extents_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Ends the run when nothing moves on either channel for too long.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Receiver: random stall bursts, plus one long hold-off on request.
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
        out_tready <= 1'b1;
      end else if (stalls_on && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(negedge clk);
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Offers one bitmap byte and waits until it is accepted.
  task automatic push_byte(input logic [MAP_W-1:0] map, input logic last_flag);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= map;
    in_tlast  <= last_flag;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    bytes_sent++;
  endtask

  // Stops offering and waits until every expected extent has come out.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (extents_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [OFFS_W-1:0] val);
    cfg_wen   <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_wen <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_geometry(input logic page, input logic [OFFS_W-1:0] base);
    write_reg(REG_PAGE_MODE, OFFS_W'(page));
    write_reg(REG_BASE_OFFSET, base);
  endtask

  // Bitmap bytes biased toward long free and used stretches and dense patterns.
  function automatic logic [MAP_W-1:0] pick_map_byte();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    case (sel)
      0, 1:    return 8'h00;
      2, 3:    return 8'hFF;
      4:       return ~(8'h01 << $urandom_range(0, 7));
      5:       return 8'h01 << $urandom_range(0, 7);
      6:       return $urandom_range(0, 1) ? 8'hAA : 8'h55;
      default: return 8'($urandom);
    endcase
  endfunction

  // Sends a table of bytes; most end with last set, a few carry random last bits.
  task automatic send_table(input int unsigned len);
    bit noisy;
    noisy = ($urandom_range(0, 7) == 0);
    for (int unsigned i = 0; i < len; i++) begin
      push_byte(pick_map_byte(), noisy ? 1'($urandom) : (i == len - 1));
    end
  endtask

  task automatic send_random(input int unsigned count);
    int unsigned stop_at;
    stop_at = bytes_sent + count;
    while (bytes_sent < stop_at) begin
      send_table($urandom_range(0, 5) == 0 ? $urandom_range(20, 60) : $urandom_range(1, 12));
    end
  endtask

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tlast   = 1'b0;
    cfg_wen    = 1'b0;
    cfg_addr   = '0;
    cfg_wdata  = '0;
    gaps_on    = 1'b1;
    stalls_on  = 1'b1;
    hold_req   = 1'b0;
    bytes_sent = 0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Data blocks from offset zero: runs across byte borders, an empty final
    // byte, four extents in one byte, and a fifth extent that is dropped.
    set_geometry(1'b0, '0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h0F, 1'b0);
    push_byte(8'hAA, 1'b1);
    push_byte(8'hFF, 1'b1);
    push_byte(8'h00, 1'b1);
    push_byte(8'h55, 1'b1);
    push_byte(8'h00, 1'b0);
    push_byte(8'hAA, 1'b1);
    push_byte(8'h80, 1'b0);
    push_byte(8'h01, 1'b1);
    drain_results();

    // Pages with a base below one page, so the start wraps.
    set_geometry(1'b1, OFFS_W'(64'h100));
    push_byte(8'h7F, 1'b1);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFE, 1'b1);
    push_byte(8'hAA, 1'b1);
    push_byte(8'h3C, 1'b1);
    drain_results();

    // Largest base in both modes, so offsets wrap at the top.
    set_geometry(1'b1, '1);
    push_byte(8'h00, 1'b1);
    push_byte(8'hF0, 1'b0);
    push_byte(8'h0F, 1'b1);
    drain_results();
    set_geometry(1'b0, '1);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b1);
    drain_results();

    // Random tables; the receiver holds off at the start so the block fills up.
    set_geometry(1'b0, OFFS_W'({$urandom, $urandom}));
    hold_req = 1'b1;
    send_random(16);
    drain_results();

    set_geometry(1'b1, OFFS_W'($urandom_range(0, 511)));
    send_random(16);
    drain_results();

    // Last part at full rate on both sides: a full table without last, whose
    // final byte is found by position.
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    set_geometry(1'b1, OFFS_W'({$urandom, $urandom}));
    push_byte(8'hFF, 1'b1);
    for (int i = 0; i < TABLE_BYTES; i++) push_byte(pick_map_byte(), 1'b0);
    push_byte(8'hFF, 1'b1);
    drain_results();

    if (fail_count == 0 && extents_pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
